@@ sv/roi_max_pooling_unit_defines.svh @@
// Assertion macros shared by the ROI max pooling checker.
`ifndef ROI_MAX_POOLING_UNIT_DEFINES_SVH
`define ROI_MAX_POOLING_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, muted during reset.
`define RMP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmp check failed");

// Next-cycle implication, sampled on clk, muted during reset.
`define RMP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmp check failed");

`endif

@@ sv/rmp_pkg.sv @@
// Types, constants and helper functions of the ROI max pooling unit.
`default_nettype none
package rmp_pkg;

  localparam int BATCHES    = 2;
  localparam int CHANNELS   = 16;
  localparam int MAX_HEIGHT = 32;
  localparam int MAX_WIDTH  = 32;
  localparam int MAX_POOLED = 8;
  localparam int ADDR_W     = $clog2(BATCHES * CHANNELS * MAX_HEIGHT * MAX_WIDTH);

  // Region sizes reach 8191, so 13 bits carry sizes and bin offsets.
  localparam int SIZE_W = 13;

  localparam logic signed [15:0] EMPTY_VALUE = 16'sh8000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POOL = 1'b1;

  // Register byte addresses.
  localparam logic [4:0] ADDR_PH    = 5'h00;
  localparam logic [4:0] ADDR_PW    = 5'h04;
  localparam logic [4:0] ADDR_SCALE = 5'h08;
  localparam logic [4:0] ADDR_MH    = 5'h0C;
  localparam logic [4:0] ADDR_MW    = 5'h10;

  localparam logic [3:0]  RST_PH    = 4'd7;
  localparam logic [3:0]  RST_PW    = 4'd7;
  localparam logic [16:0] RST_SCALE = 17'd4096;
  localparam logic [5:0]  RST_MH    = 6'd32;
  localparam logic [5:0]  RST_MW    = 6'd32;

  typedef struct packed {
    logic               operation;
    logic               batch_index;
    logic [3:0]         channel_index;
    logic [4:0]         row_index;
    logic [4:0]         column_index;
    logic signed [15:0] feature_value;
    logic signed [15:0] box_x1;
    logic signed [15:0] box_y1;
    logic signed [15:0] box_x2;
    logic signed [15:0] box_y2;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pooled_value;
    logic [2:0]         bin_row;
    logic [2:0]         bin_column;
    logic               last_bin;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  pooled_height;
    logic [3:0]  pooled_width;
    logic [16:0] spatial_scale;
    logic [5:0]  map_height;
    logic [5:0]  map_width;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       write_mem;
    logic       capture;
    logic       mul;
    logic       rnd;
    logic [1:0] corner;
    logic       size;
    logic       div_start;
    logic       div_latch;
    logic       div_axis;
    logic       row_init;
    logic       row_load;
    logic       col_init;
    logic       col_load;
    logic       scan;
    logic       emit;
    logic       col_adv;
    logic       row_adv;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic bin_empty;
    logic scan_last;
    logic col_last;
    logic row_last;
  } sts_t;

  // Effective bin count: zero acts as one, large values saturate.
  function automatic logic [3:0] bins_of(input logic [3:0] p);
    if (p == 4'd0) begin
      return 4'd1;
    end else if (p > 4'(MAX_POOLED)) begin
      return 4'(MAX_POOLED);
    end
    return p;
  endfunction

  // Clamp a signed map coordinate to [0, hi].
  function automatic logic [5:0] clamp_map(input logic signed [14:0] v,
                                           input logic [5:0] hi);
    if (v < 15'sd0) begin
      return 6'd0;
    end else if (v > $signed({9'd0, hi})) begin
      return hi;
    end
    return v[5:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/rmp_div.sv @@
// Restoring divider, one quotient bit per cycle, for region size over bin count.
`default_nettype none
module rmp_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rmp_pkg::SIZE_W-1:0] dividend,
  input  wire logic [3:0]                 divisor,
  output logic                            done,
  output logic [rmp_pkg::SIZE_W-1:0]      quo,
  output logic [3:0]                      rem
);
  import rmp_pkg::*;

  logic                run_r;
  logic                done_r;
  logic [3:0]          cnt_r;
  logic [SIZE_W-1:0]   quo_r;
  logic [3:0]          rem_r;
  logic [4:0]          trial;
  logic                ge;

  // Shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_r, quo_r[SIZE_W-1]};
    ge    = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 4'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(SIZE_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Iterate the partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= 4'd0;
    end else if (run_r) begin
      quo_r <= {quo_r[SIZE_W-2:0], ge};
      rem_r <= ge ? 4'(trial - {1'b0, divisor}) : trial[3:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

@@ sv/rmp_ctrl.sv @@
// Sequencer of the ROI max pooling unit: store writes, scaling, division, bin walk and scan.
`default_nettype none
module rmp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          operation,
  input  wire rmp_pkg::sts_t sts,
  output rmp_pkg::cmd_t      cmd,
  output logic               busy
);
  import rmp_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL     = 4'd1;
  localparam logic [3:0] S_RND     = 4'd2;
  localparam logic [3:0] S_SIZE    = 4'd3;
  localparam logic [3:0] S_DIVH_GO = 4'd4;
  localparam logic [3:0] S_DIVH_WT = 4'd5;
  localparam logic [3:0] S_DIVW_GO = 4'd6;
  localparam logic [3:0] S_DIVW_WT = 4'd7;
  localparam logic [3:0] S_ROW     = 4'd8;
  localparam logic [3:0] S_COL     = 4'd9;
  localparam logic [3:0] S_SCAN    = 4'd10;
  localparam logic [3:0] S_DRAIN   = 4'd11;
  localparam logic [3:0] S_EMIT    = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [1:0] cnr_r, cnr_nxt;

  // Decode state into datapath commands and the next state.
  always_comb begin
    cmd        = '0;
    cmd.corner = cnr_r;
    state_nxt  = state_r;
    cnr_nxt    = cnr_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (operation == OP_POOL) begin
            cmd.capture = 1'b1;
            cnr_nxt     = 2'd0;
            state_nxt   = S_MUL;
          end else begin
            cmd.write_mem = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd = 1'b1;
        if (cnr_r == 2'd3) begin
          state_nxt = S_SIZE;
        end else begin
          cnr_nxt   = cnr_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = S_DIVH_GO;
      end
      S_DIVH_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVH_WT;
      end
      S_DIVH_WT: begin
        if (sts.div_done) begin
          cmd.div_latch = 1'b1;
          state_nxt     = S_DIVW_GO;
        end
      end
      S_DIVW_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_axis  = 1'b1;
        state_nxt     = S_DIVW_WT;
      end
      S_DIVW_WT: begin
        cmd.div_axis = 1'b1;
        if (sts.div_done) begin
          cmd.div_latch = 1'b1;
          cmd.row_init  = 1'b1;
          state_nxt     = S_ROW;
        end
      end
      S_ROW: begin
        cmd.row_load = 1'b1;
        cmd.col_init = 1'b1;
        state_nxt    = S_COL;
      end
      S_COL: begin
        cmd.col_load = 1'b1;
        state_nxt    = sts.bin_empty ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit    = 1'b1;
        cmd.col_adv = 1'b1;
        if (sts.col_last) begin
          cmd.row_adv = 1'b1;
          state_nxt   = sts.row_last ? S_IDLE : S_ROW;
        end else begin
          state_nxt = S_COL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnr_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnr_r   <= cnr_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule
`default_nettype wire

@@ sv/rmp_dp.sv @@
// Datapath: feature store, corner scaling, bin bounds, scan and max, result register.
`default_nettype none
module rmp_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rmp_pkg::in_item_t in_data,
  input  wire rmp_pkg::cfg_t     cfg,
  input  wire rmp_pkg::cmd_t     cmd,
  output rmp_pkg::sts_t          sts,
  output logic                   out_valid,
  output rmp_pkg::out_item_t     out_data
);
  import rmp_pkg::*;

  logic signed [15:0] mem [2**ADDR_W];
  logic signed [15:0] mem_q_r;
  logic               rd_vld_r;

  // Captured pool request.
  logic               bat_r;
  logic [3:0]         chn_r;
  logic signed [15:0] bx1_r, by1_r, bx2_r, by2_r;

  // Scaling.
  logic signed [15:0] box_sel;
  logic [16:0]        mag;
  logic [33:0]        prod_r;
  logic               neg_r;
  logic [34:0]        rsum;
  logic [SIZE_W-2:0]  rq;
  logic [SIZE_W-1:0]  cval;
  logic [SIZE_W-1:0]  x1_r, y1_r, x2_r, y2_r;

  // Region sizes and per-bin step.
  logic [SIZE_W:0]    dy, dx;
  logic [SIZE_W-1:0]  rh_r, rw_r;
  logic [SIZE_W-1:0]  hqa_r, wqa_r;
  logic [3:0]         hra_r, wra_r;
  logic [3:0]         ph_n, pw_n;
  logic [5:0]         hmax, wmax;

  // Divider.
  logic               div_done;
  logic [SIZE_W-1:0]  div_quo;
  logic [3:0]         div_rem;

  // Bin walk.
  logic [SIZE_W-1:0]  hq_r, wq_r, hqn, wqn;
  logic [3:0]         hr_r, wr_r, hrn, wrn;
  logic [4:0]         hsum, wsum;
  logic               hge, wge;
  logic [2:0]         ph_r, pw_r;
  logic [5:0]         hs_r, he_r, ws_r, we_r;
  logic [5:0]         hs_c, he_c, ws_c, we_c;
  logic [4:0]         h_r, w_r;
  logic signed [15:0] best_r;

  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic               col_end, row_end;

  assign ph_n = bins_of(cfg.pooled_height);
  assign pw_n = bins_of(cfg.pooled_width);
  assign hmax = (cfg.map_height > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : cfg.map_height;
  assign wmax = (cfg.map_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : cfg.map_width;

  // Feature store: one write port for loads, one registered read port for scans.
  assign wr_addr = {in_data.batch_index, in_data.channel_index,
                    in_data.row_index, in_data.column_index};
  assign rd_addr = {bat_r, chn_r, h_r, w_r};

  always_ff @(posedge clk) begin
    if (cmd.write_mem) begin
      mem[wr_addr] <= in_data.feature_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Hold the pool request.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bat_r <= in_data.batch_index;
      chn_r <= in_data.channel_index;
      bx1_r <= in_data.box_x1;
      by1_r <= in_data.box_y1;
      bx2_r <= in_data.box_x2;
      by2_r <= in_data.box_y2;
    end
  end

  // Pick one corner and take its magnitude.
  always_comb begin
    case (cmd.corner)
      2'd0:    box_sel = bx1_r;
      2'd1:    box_sel = by1_r;
      2'd2:    box_sel = bx2_r;
      default: box_sel = by2_r;
    endcase
    mag = box_sel[15] ? (~{box_sel[15], box_sel} + 17'd1) : {1'b0, box_sel};
  end

  // Multiply by the scale, then round half away from zero.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= {17'd0, mag} * {17'd0, cfg.spatial_scale};
      neg_r  <= box_sel[15];
    end
  end

  always_comb begin
    rsum = {1'b0, prod_r} + 35'd524288;
    rq   = rsum[31:20];
    cval = neg_r ? (13'd0 - {1'b0, rq}) : {1'b0, rq};
  end

  always_ff @(posedge clk) begin
    if (cmd.rnd) begin
      case (cmd.corner)
        2'd0:    x1_r <= cval;
        2'd1:    y1_r <= cval;
        2'd2:    x2_r <= cval;
        default: y2_r <= cval;
      endcase
    end
  end

  // Region size, at least one.
  always_comb begin
    dy = {y2_r[SIZE_W-1], y2_r} - {y1_r[SIZE_W-1], y1_r} + 14'd1;
    dx = {x2_r[SIZE_W-1], x2_r} - {x1_r[SIZE_W-1], x1_r} + 14'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.size) begin
      rh_r <= ($signed(dy) < 14'sd1) ? 13'd1 : dy[SIZE_W-1:0];
      rw_r <= ($signed(dx) < 14'sd1) ? 13'd1 : dx[SIZE_W-1:0];
    end
  end

  rmp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (cmd.div_axis ? rw_r : rh_r),
    .divisor  (cmd.div_axis ? pw_n : ph_n),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Keep the per-bin quotient and remainder steps.
  always_ff @(posedge clk) begin
    if (cmd.div_latch) begin
      if (cmd.div_axis) begin
        wqa_r <= div_quo;
        wra_r <= div_rem;
      end else begin
        hqa_r <= div_quo;
        hra_r <= div_rem;
      end
    end
  end

  // Step floor(i*size/P) to the next bin with one compare and subtract.
  always_comb begin
    hsum = {1'b0, hr_r} + {1'b0, hra_r};
    hge  = hsum >= {1'b0, ph_n};
    hrn  = hge ? 4'(hsum - {1'b0, ph_n}) : hsum[3:0];
    hqn  = hq_r + hqa_r + 13'(hge);
    wsum = {1'b0, wr_r} + {1'b0, wra_r};
    wge  = wsum >= {1'b0, pw_n};
    wrn  = wge ? 4'(wsum - {1'b0, pw_n}) : wsum[3:0];
    wqn  = wq_r + wqa_r + 13'(wge);
  end

  // Offset bounds by the region start and clamp to the map.
  always_comb begin
    hs_c = clamp_map($signed({2'b00, hq_r}) + $signed({{2{y1_r[SIZE_W-1]}}, y1_r}), hmax);
    he_c = clamp_map($signed({2'b00, hqn + 13'(hrn != 4'd0)})
                     + $signed({{2{y1_r[SIZE_W-1]}}, y1_r}), hmax);
    ws_c = clamp_map($signed({2'b00, wq_r}) + $signed({{2{x1_r[SIZE_W-1]}}, x1_r}), wmax);
    we_c = clamp_map($signed({2'b00, wqn + 13'(wrn != 4'd0)})
                     + $signed({{2{x1_r[SIZE_W-1]}}, x1_r}), wmax);
  end

  // Advance row and column bin accumulators.
  always_ff @(posedge clk) begin
    if (cmd.row_init) begin
      hq_r <= '0;
      hr_r <= 4'd0;
      ph_r <= 3'd0;
    end else if (cmd.row_adv) begin
      hq_r <= hqn;
      hr_r <= hrn;
      ph_r <= ph_r + 3'd1;
    end
    if (cmd.col_init) begin
      wq_r <= '0;
      wr_r <= 4'd0;
      pw_r <= 3'd0;
    end else if (cmd.col_adv && !(cmd.row_adv)) begin
      wq_r <= wqn;
      wr_r <= wrn;
      pw_r <= pw_r + 3'd1;
    end
    if (cmd.row_load) begin
      hs_r <= hs_c;
      he_r <= he_c;
    end
  end

  // Latch column bounds, start the scan and track the bin maximum.
  assign col_end = ({1'b0, w_r} + 6'd1) == we_r;
  assign row_end = ({1'b0, h_r} + 6'd1) == he_r;

  always_ff @(posedge clk) begin
    if (cmd.col_load) begin
      ws_r   <= ws_c;
      we_r   <= we_c;
      h_r    <= hs_r[4:0];
      w_r    <= ws_c[4:0];
      best_r <= EMPTY_VALUE;
    end else begin
      if (cmd.scan) begin
        if (col_end) begin
          w_r <= ws_r[4:0];
          h_r <= h_r + 5'd1;
        end else begin
          w_r <= w_r + 5'd1;
        end
      end
      if (rd_vld_r && (mem_q_r > best_r)) begin
        best_r <= mem_q_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
    end
  end

  always_comb begin
    sts.div_done  = div_done;
    sts.bin_empty = (hs_r >= he_r) || (ws_c >= we_c);
    sts.scan_last = col_end && row_end;
    sts.col_last  = {1'b0, pw_r} == (pw_n - 4'd1);
    sts.row_last  = {1'b0, ph_r} == (ph_n - 4'd1);
  end

  // Result register: one strobe per bin.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.pooled_value <= best_r;
      out_data.bin_row      <= ph_r;
      out_data.bin_column   <= pw_r;
      out_data.last_bin     <= sts.col_last && sts.row_last;
    end
  end

endmodule
`default_nettype wire

@@ sv/roi_max_pooling_unit.sv @@
// Top level of the ROI max pooling unit: register port, controller and datapath.
//
//  channel   ports                                   handshake
//  input     start, busy, in_data                    accept when start & !busy
//  result    out_valid, out_data                     one-cycle strobe, no stall
//  config    psel, penable, pwrite, paddr, pwdata    write in access cycle
//
// A load request is written into the feature store at its accept edge; busy
// stays low. A pool request scales the four corners (multiply, round), sizes
// the region, divides height, then width, by the bin count; then it loads row
// bounds per bin row and column bounds per bin, reads a non-empty bin one store
// cell per cycle, then drains; the single store read port sets the rate. Each
// result shows in the cycle after its emit state. Reset clears control state
// and configuration; the store holds nothing valid until written.
`default_nettype none
module roi_max_pooling_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire rmp_pkg::in_item_t in_data,
  output logic                   out_valid,
  output rmp_pkg::out_item_t     out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import rmp_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Write configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pooled_height <= RST_PH;
      cfg_r.pooled_width  <= RST_PW;
      cfg_r.spatial_scale <= RST_SCALE;
      cfg_r.map_height    <= RST_MH;
      cfg_r.map_width     <= RST_MW;
    end else if (cfg_wr) begin
      case (paddr)
        ADDR_PH:    cfg_r.pooled_height <= pwdata[3:0];
        ADDR_PW:    cfg_r.pooled_width  <= pwdata[3:0];
        ADDR_SCALE: cfg_r.spatial_scale <= pwdata[16:0];
        ADDR_MH:    cfg_r.map_height    <= pwdata[5:0];
        ADDR_MW:    cfg_r.map_width     <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  // Read back configuration registers.
  always_comb begin
    case (paddr)
      ADDR_PH:    prdata = {28'd0, cfg_r.pooled_height};
      ADDR_PW:    prdata = {28'd0, cfg_r.pooled_width};
      ADDR_SCALE: prdata = {15'd0, cfg_r.spatial_scale};
      ADDR_MH:    prdata = {26'd0, cfg_r.map_height};
      ADDR_MW:    prdata = {26'd0, cfg_r.map_width};
      default:    prdata = 32'd0;
    endcase
  end

  rmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_data.operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  rmp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ sv/rmp_checker.sv @@
// Port-level checks of the ROI max pooling unit and their bind.
`default_nettype none
`include "roi_max_pooling_unit_defines.svh"
module rmp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire rmp_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire rmp_pkg::out_item_t out_data
);
  import rmp_pkg::*;

  // A result only follows a busy cycle.
  `RMP_ASSERT_IMP(a_out_after_busy, out_valid, $past(busy))
  // A pool request occupies the block.
  `RMP_ASSERT_NXT(a_pool_busy, start && !busy && (in_data.operation == OP_POOL), busy)
  // A load request leaves the block free.
  `RMP_ASSERT_NXT(a_load_free, start && !busy && (in_data.operation == OP_LOAD), !busy)
  // The final bin is never followed at once by another result.
  `RMP_ASSERT_NXT(a_last_gap, out_valid && out_data.last_bin, !out_valid)

endmodule

bind roi_max_pooling_unit rmp_checker u_rmp_checker (.*);
`default_nettype wire
